[hdl/elts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elts_pkg
// Shared sizes, register indexes, item kinds and the token that travels down
// the cell chain of the tick scheduler.
// ----------------------------------------------------------------------------
package elts_pkg;

  localparam int TASKS     = 16;
  localparam int TIME_BITS = 32;
  localparam int TASK_W    = (TASKS > 1) ? $clog2(TASKS) : 1;

  localparam int SLOT_W     = 4;
  localparam int VAL_W      = 16;
  localparam int OUT_TIME_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 2'd1;

  // input item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic                 found;
    logic                 done;
    logic [TASK_W-1:0]    idx;
    logic [TIME_BITS-1:0] key;
  } token_t;

endpackage

[hdl/edf_llf_tick_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_llf_tick_scheduler
// Periodic task scheduler driven by tick items, picking by earliest deadline
// or least laxity over a chain of task cells.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           contents
//  s_*      in         s_tvalid/s_tready   load slot or time tick
//  m_*      out        m_tvalid/m_tready   one result per tick
//  cfg_*    in         cfg_valid/cfg_ready policy_mode, task_count writes
//
//  A load is written into its slot as it is accepted. A tick is accepted,
//  then the best-candidate token ripples through the cell chain, each cell
//  registering it, and finally the winner is committed and the result is
//  registered. A stalled result holds the commit; the input is taken again
//  once the tick is committed, even while its result still waits.
//  Reset clears time, configuration and control; slot contents stay
//  undefined until loaded. Configuration is always ready.
//
module edf_llf_tick_scheduler import elts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: task_slot [3:0], task_period [19:4], task_cost [35:20], zero pad
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,
  // s_tuser: func [0]
  input  logic                  s_tuser,
  // m_tdata: chosen_task [3:0], job_finished [4], tick_time [36:5], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,
  // m_tuser: idle [0]
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t               state;
  logic [TASK_W-1:0]    scan_cnt;
  logic [TIME_BITS-1:0] now;
  logic                 policy;
  logic [4:0]           task_count;

  logic                  out_valid;
  logic [SLOT_W-1:0]     out_chosen;
  logic                  out_done;
  logic                  out_idle;
  logic [OUT_TIME_W-1:0] out_time;

  token_t               tok [TASKS+1];
  token_t               best;
  logic                 in_fire;
  logic                 load_fire;
  logic                 out_free;
  logic                 commit;
  logic [SLOT_W-1:0]    in_slot;
  logic [VAL_W-1:0]     in_period;
  logic [VAL_W-1:0]     in_cost;

  assign in_slot   = s_tdata[3:0];
  assign in_period = s_tdata[19:4];
  assign in_cost   = s_tdata[35:20];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign load_fire = in_fire && (s_tuser == FUNC_LOAD);
  assign out_free  = !out_valid || m_tready;
  assign best      = tok[TASKS];
  // apply the winner's update in the cycle its result is registered
  assign commit    = (state == S_DONE) && out_free && best.found;

  // the chain starts from an empty candidate
  assign tok[0] = '0;

  for (genvar i = 0; i < TASKS; i++) begin : g_cell
    elts_cell u_cell (
      .clk         (clk),
      .cell_idx    (TASK_W'(i)),
      .active      (32'(i) < 32'(task_count)),
      .policy      (policy),
      .now         (now),
      .load_en     (load_fire && (32'(in_slot) == 32'(i))),
      .load_period (in_period),
      .load_cost   (in_cost),
      .commit      (commit),
      .win_idx     (best.idx),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_cnt   <= '0;
      now        <= '0;
      policy     <= 1'b0;
      task_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POLICY:     policy     <= cfg_data[0];
          REG_TASK_COUNT: task_count <= cfg_data[4:0];
          default: ;
        endcase
      end

      // drop the result once the transfer completes; in S_DONE a completed
      // transfer frees the register and the new result takes its place
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && (s_tuser == FUNC_TICK)) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // advance until the token has passed the last cell
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == TASK_W'(TASKS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_idle   <= !best.found;
            out_chosen <= best.found ? SLOT_W'(best.idx) : '0;
            out_done   <= best.found && best.done;
            out_time   <= OUT_TIME_W'(now);
            now        <= now + 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_time, out_done, out_chosen};
  assign m_tuser  = out_idle;

endmodule

[hdl/elts_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elts_cell
// One task slot: holds its timing state, registers its selection key and
// passes the better of its own key and the incoming token to the next cell.
// ----------------------------------------------------------------------------
module elts_cell import elts_pkg::*; (
  input  logic                 clk,
  input  logic [TASK_W-1:0]    cell_idx,
  input  logic                 active,
  input  logic                 policy,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 load_en,
  input  logic [VAL_W-1:0]     load_period,
  input  logic [VAL_W-1:0]     load_cost,
  input  logic                 commit,
  input  logic [TASK_W-1:0]    win_idx,
  input  token_t               tok_in,
  output token_t               tok_out
);

  logic [TIME_BITS-1:0] deadline;
  logic [VAL_W-1:0]     exec_cnt;
  logic [VAL_W-1:0]     period;
  logic [VAL_W-1:0]     cost;
  logic                 elig;
  logic [TIME_BITS-1:0] key;
  logic                 done;

  logic [TIME_BITS-1:0] gap;
  logic                 in_window;
  logic [VAL_W-1:0]     rem;
  logic [TIME_BITS-1:0] val;
  logic [VAL_W:0]       cnt_inc;
  logic                 done_next;
  logic                 take;

  always_comb begin
    gap       = deadline - now;
    in_window = gap[TIME_BITS-1] || (gap <= TIME_BITS'(period));
    rem       = (cost > exec_cnt) ? (cost - exec_cnt) : '0;
    val       = policy ? (gap - TIME_BITS'(rem)) : gap;
    cnt_inc   = {1'b0, exec_cnt} + 1'b1;
    done_next = cnt_inc >= {1'b0, cost};
    take      = elig && (!tok_in.found || (key < tok_in.key));
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      period   <= load_period;
      cost     <= load_cost;
      deadline <= TIME_BITS'(load_period);
      exec_cnt <= '0;
    end else if (commit && (win_idx == cell_idx)) begin
      if (done) begin
        deadline <= deadline + TIME_BITS'(period);
        exec_cnt <= '0;
      end else begin
        exec_cnt <= cnt_inc[VAL_W-1:0];
      end
    end
    // flip the sign bit so an unsigned compare orders signed keys
    elig <= active && in_window;
    key  <= val ^ {1'b1, {(TIME_BITS-1){1'b0}}};
    done <= done_next;
    if (take) begin
      tok_out <= '{found: 1'b1, done: done, idx: cell_idx, key: key};
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

[hdl/elts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elts_checker
// Port-level checks for the tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module elts_checker import elts_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [39:0]           m_tdata,
  input logic                  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an idle tick reports slot zero and no finished job
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[4:0] == 5'd0))
    else $error("idle result carries a task");

  // a tick closes the input while the chain scans
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_TICK) |=> !s_tready)
    else $error("input open right after a tick");

  // a new result follows a cycle with the input closed
  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a scan");

endmodule

bind edf_llf_tick_scheduler elts_checker u_elts_checker (.*);
